FILE: hw/rtl/bwk_pkg.sv
// Package for the burst window key search tracker.
// Holds sizes, command and status codes, register indexes and the status function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bwk_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int BURST_BITS   = 64;

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int FW     = $clog2(WINDOW_DEPTH + 1);
  localparam int WORD_W = 64;
  localparam int SESS_W = 32;
  localparam int KEY_W  = 16;
  localparam int WIN_W  = 6;
  localparam int INT_W  = 16;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 16;
  localparam int CMP_W  = 7;

  typedef enum logic [1:0] {
    CMD_BURST  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_RESULT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_COLLECTING = 3'd1,
    ST_SEARCHING  = 3'd2,
    ST_KEYED      = 3'd3,
    ST_MISS       = 3'd4
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_WIN_LO      = 2'd0,
    REG_WIN_HI      = 2'd1,
    REG_RECHECK_GAP = 2'd2
  } reg_idx_e;

  // Request toward the window memory.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

  function automatic status_e status_of(input logic active, input logic pending,
                                        input logic missed, input logic [KEY_W-1:0] key);
    status_e s;
    if (!active) begin
      s = ST_IDLE;
    end else if (pending) begin
      s = ST_SEARCHING;
    end else if (missed && key == '0) begin
      s = ST_MISS;
    end else if (key != '0) begin
      s = ST_KEYED;
    end else begin
      s = ST_COLLECTING;
    end
    return s;
  endfunction

  // Window size register values are clamped to 1 .. WINDOW_DEPTH where they are used.
  function automatic logic [FW-1:0] clamp_win(input logic [WIN_W-1:0] v);
    logic [FW-1:0] r;
    if (v == '0) begin
      r = FW'(1);
    end else if (CMP_W'(v) > CMP_W'(WINDOW_DEPTH)) begin
      r = FW'(WINDOW_DEPTH);
    end else begin
      r = FW'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bwk_stream_if.sv
// Channel interfaces of the burst window key search tracker: input, output, config.
// Depends on bwk_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bwk_in_if import bwk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [WORD_W-1:0] burst_word;
  logic [SESS_W-1:0] result_session;
  logic [KEY_W-1:0]  result_key;

  modport source (output valid, command, burst_word, result_session, result_key,
                  input ready);
  modport sink (input valid, command, burst_word, result_session, result_key,
                output ready);
endinterface

interface bwk_out_if import bwk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              request_flag;
  logic [SESS_W-1:0] out_session;
  logic [KEY_W-1:0]  out_key;
  logic [WORD_W-1:0] out_burst;
  logic              last_in_run;
  logic [2:0]        status;

  modport source (output valid, request_flag, out_session, out_key, out_burst,
                  last_in_run, status, input ready);
  modport sink (input valid, request_flag, out_session, out_key, out_burst,
                last_in_run, status, output ready);
endinterface

interface bwk_cfg_if import bwk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bwk_window_ram.sv
// Window store: one write port, one read port, registered read data.
// Depends on bwk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwk_window_ram import bwk_pkg::*; (
  input  wire logic                  clk_i,
  input  wire ram_req_t              req_i,
  input  wire logic [BURST_BITS-1:0] wdata_i,
  output logic      [BURST_BITS-1:0] rdata_o
);

  logic [BURST_BITS-1:0] mem [WINDOW_DEPTH];
  logic [BURST_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bwk_ctrl.sv
// Session control, config registers, request sequencer and output register.
// Depends on bwk_pkg and the channel interfaces; drives bwk_window_ram.
`timescale 1ns / 1ps
`default_nettype none

module bwk_ctrl import bwk_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bwk_in_if.sink                     in_i,
  bwk_out_if.source                  out_o,
  bwk_cfg_if.sink                    cfg_i,
  output ram_req_t                   ram_req_o,
  output logic      [BURST_BITS-1:0] ram_wdata_o,
  input  wire logic [BURST_BITS-1:0] ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_STATUS = 3'b010,
    S_RUN    = 3'b100
  } fsm_e;

  fsm_e state_q, state_d;

  logic [WIN_W-1:0] min_win_q, max_win_q;
  logic [INT_W-1:0] recheck_q;

  logic              active_q, active_d;
  logic              pending_q, pending_d;
  logic              missed_q, missed_d;
  logic              made_q, made_d;
  logic [SESS_W-1:0] sess_q, sess_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [31:0]       bcnt_q, bcnt_d;
  logic [31:0]       last_req_q, last_req_d;
  logic [AW-1:0]     head_q, head_d;
  logic [FW-1:0]     fill_q, fill_d;

  logic [AW-1:0] raddr_q, raddr_d;
  logic [FW-1:0] left_q, left_d;
  logic          rd_pend_q, rd_pend_d;
  logic          rd_last_q, rd_last_d;

  logic              out_valid_q, out_valid_d;
  logic              out_flag_q;
  logic              out_last_q;
  logic [SESS_W-1:0] out_sess_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [WORD_W-1:0] out_burst_q;
  status_e           out_status_q;

  logic          in_fire, out_free, issue, load_status, load_run;
  logic [FW-1:0] mn, mx, fill_base, take;
  logic [FW:0]   fill_inc;
  logic [FW-1:0] fill_new;
  logic          pend_b, made_b;
  logic [31:0]   last_b;
  logic          want_req;
  logic [AW-1:0] head_new;
  logic [AW:0]   start_sum;
  logic [AW-1:0] start_addr;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign mn = clamp_win(min_win_q);
  assign mx = clamp_win(max_win_q);

  // A burst that finds no active session starts a fresh one.
  assign fill_base = active_q ? fill_q : '0;
  assign pend_b    = active_q ? pending_q : 1'b0;
  assign made_b    = active_q ? made_q : 1'b0;
  assign last_b    = active_q ? last_req_q : '0;
  assign fill_inc  = {1'b0, fill_base} + (FW+1)'(1);
  assign fill_new  = (fill_inc > {1'b0, mx}) ? mx : fill_inc[FW-1:0];
  assign head_new  = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign take      = made_b ? mx : mn;

  always_comb begin
    want_req = 1'b0;
    if (!pend_b && fill_new >= mn) begin
      if (!made_b) begin
        want_req = 1'b1;
      end else if ((bcnt_q - last_b) >= 32'(recheck_q) && fill_new >= mx) begin
        want_req = 1'b1;
      end
    end
  end

  // Oldest entry of the newest take bursts, wrapped into the store.
  assign start_sum  = {1'b0, head_new} + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(take);
  assign start_addr = (start_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                      AW'(start_sum - (AW+1)'(WINDOW_DEPTH)) : start_sum[AW-1:0];

  // A read is issued only when no read word is waiting or the waiting word is leaving this cycle.
  assign issue       = (state_q == S_RUN) && (left_q != '0) && (!rd_pend_q || out_free);
  assign load_status = (state_q == S_STATUS) && out_free;
  assign load_run    = (state_q == S_RUN) && rd_pend_q && out_free;

  always_comb begin
    ram_req_o.we    = in_fire && (in_i.command == CMD_BURST);
    ram_req_o.waddr = head_q;
    ram_req_o.re    = issue;
    ram_req_o.raddr = raddr_q;
  end
  assign ram_wdata_o = in_i.burst_word[BURST_BITS-1:0];

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    pending_d  = pending_q;
    missed_d   = missed_q;
    made_d     = made_q;
    sess_d     = sess_q;
    key_d      = key_q;
    bcnt_d     = bcnt_q;
    last_req_d = last_req_q;
    head_d     = head_q;
    fill_d     = fill_q;
    raddr_d    = raddr_q;
    left_d     = left_q;
    rd_pend_d  = rd_pend_q;
    rd_last_d  = rd_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_STATUS;
          case (in_i.command)
            CMD_BURST: begin
              if (!active_q) begin
                sess_d   = sess_q + 32'd1;
                active_d = 1'b1;
                missed_d = 1'b0;
              end
              pending_d  = pend_b;
              made_d     = made_b;
              last_req_d = last_b;
              head_d     = head_new;
              fill_d     = fill_new;
              bcnt_d     = bcnt_q + 32'd1;
              if (want_req) begin
                pending_d  = 1'b1;
                made_d     = 1'b1;
                last_req_d = bcnt_q;
                raddr_d    = start_addr;
                left_d     = take;
                state_d    = S_RUN;
              end
            end
            CMD_CLEAR: begin
              if (active_q) begin
                active_d   = 1'b0;
                pending_d  = 1'b0;
                made_d     = 1'b0;
                last_req_d = '0;
                fill_d     = '0;
              end
            end
            CMD_RESULT: begin
              if (in_i.result_session == sess_q) begin
                pending_d = 1'b0;
                if (in_i.result_key != '0) begin
                  key_d    = in_i.result_key;
                  missed_d = 1'b0;
                end else begin
                  missed_d = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STATUS: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (load_run) begin
          rd_pend_d = 1'b0;
          if (rd_last_q) begin
            state_d = S_IDLE;
          end
        end
        if (issue) begin
          rd_pend_d = 1'b1;
          rd_last_d = (left_q == FW'(1));
          left_d    = left_q - FW'(1);
          raddr_d   = (raddr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : raddr_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_status || load_run) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_win_q   <= WIN_W'(4);
      max_win_q   <= WIN_W'(16);
      recheck_q   <= INT_W'(16);
      active_q    <= 1'b0;
      pending_q   <= 1'b0;
      missed_q    <= 1'b0;
      made_q      <= 1'b0;
      sess_q      <= '0;
      key_q       <= '0;
      bcnt_q      <= '0;
      last_req_q  <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      raddr_q     <= '0;
      left_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      pending_q   <= pending_d;
      missed_q    <= missed_d;
      made_q      <= made_d;
      sess_q      <= sess_d;
      key_q       <= key_d;
      bcnt_q      <= bcnt_d;
      last_req_q  <= last_req_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      raddr_q     <= raddr_d;
      left_q      <= left_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_WIN_LO:      min_win_q <= cfg_i.data[WIN_W-1:0];
          REG_WIN_HI:      max_win_q <= cfg_i.data[WIN_W-1:0];
          REG_RECHECK_GAP: recheck_q <= cfg_i.data[INT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output word payload; the session state is stable while a word is built.
  always_ff @(posedge clk_i) begin
    if (load_status || load_run) begin
      out_sess_q   <= sess_q;
      out_key_q    <= key_q;
      out_status_q <= status_of(active_q, pending_q, missed_q, key_q);
      out_flag_q   <= load_run;
      out_last_q   <= load_run ? rd_last_q : 1'b1;
      out_burst_q  <= load_run ? WORD_W'(ram_rdata_i) : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.request_flag = out_flag_q;
  assign out_o.out_session  = out_sess_q;
  assign out_o.out_key      = out_key_q;
  assign out_o.out_burst    = out_burst_q;
  assign out_o.last_in_run  = out_last_q;
  assign out_o.status       = out_status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/burst_window_key_search_tracker.sv
// Top level of the burst window key search tracker.
// Depends on bwk_pkg, the channel interfaces, bwk_ctrl and bwk_window_ram.
//
// Usage:
//   in_i carries one input word: a burst (command 0), a session clear
//   (command 1) or a key search result (command 2). out_o carries result
//   words; the last word caused by one input has last_in_run set.
//   cfg_i writes the first request size (index 0), the window capacity (1)
//   and the minimum burst gap between requests (2); it is always ready and
//   should be used while the block is idle.
// Flow:
//   in_i is ready only while no input is being worked on. A status-only
//   input is accepted, then its word is loaded into the output register
//   once that register is free. A burst that starts a request run sends
//   take words, at most WINDOW_DEPTH, one per cycle while out_o is ready,
//   from the window memory (one read port, registered read data).
// Reset:
//   rst_ni clears all session state and restores the register defaults;
//   the window memory needs no clearing, as only bursts of the current
//   session are ever read back.
// Stalls:
//   When out_o is not ready the word holds in the output register, and a
//   run pauses with its next burst kept in the memory read register.
`timescale 1ns / 1ps
`default_nettype none

module burst_window_key_search_tracker import bwk_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bwk_in_if.sink    in_i,
  bwk_out_if.source out_o,
  bwk_cfg_if.sink   cfg_i
);

  ram_req_t              ram_req;
  logic [BURST_BITS-1:0] ram_wdata;
  logic [BURST_BITS-1:0] ram_rdata;

  bwk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_i       (cfg_i),
    .ram_req_o   (ram_req),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  bwk_window_ram u_window_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
